// File: hdl/hajf_pkg.sv
// Package for the hash anti-join filter: sizes, codes, payload structs and
// state machine types. No dependencies; every other file of the block imports it.
package hajf_pkg;

  localparam int unsigned SET_CAPACITY  = 1024;  // power of two
  localparam int unsigned MAX_KEY_WORDS = 4;
  localparam int unsigned IN_KEY_WORDS  = 4;
  localparam int unsigned WORD_W        = 64;
  localparam int unsigned HALF_W        = WORD_W / 2;
  localparam int unsigned TAG_W         = 32;
  localparam int unsigned ACT_W         = 2;
  localparam int unsigned KW_W          = 3;
  localparam int unsigned IDX_W         = $clog2(SET_CAPACITY);
  localparam int unsigned CNT_W         = IDX_W + 1;
  localparam int unsigned WIDX_W        = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
  localparam int unsigned HASH_SHIFT    = 29;

  localparam logic [WORD_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [KW_W-1:0]   KW_RESET  = KW_W'(1);

  typedef logic [MAX_KEY_WORDS-1:0][WORD_W-1:0] hajf_key_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_PROBE  = 2'd2,
    ACT_NOP    = 2'd3
  } hajf_action_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] key_word_0;
    logic [WORD_W-1:0] key_word_1;
    logic [WORD_W-1:0] key_word_2;
    logic [WORD_W-1:0] key_word_3;
    logic [TAG_W-1:0]  row_tag;
  } hajf_in_t;

  typedef struct packed {
    logic [TAG_W-1:0] out_tag;
    logic             overflow;
  } hajf_out_t;

  typedef struct packed {
    logic             key_en;
    logic             vld_en;
    logic             vld;
    logic [IDX_W-1:0] addr;
  } hajf_wr_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_READ,
    ST_CHECK,
    ST_EMIT
  } hajf_state_e;

  typedef enum logic [2:0] {
    HP_IDLE,
    HP_LOAD,
    HP_M0,
    HP_M1,
    HP_M2,
    HP_MIX
  } hajf_hphase_e;

endpackage

// File: hdl/hajf_hash.sv
// Iterative multiply-xorshift key hash built around one shared 32x32 multiplier.
// Each key word passes through the load, M0, M1, M2 and mix phases. Depends on hajf_pkg.
module hajf_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  hajf_pkg::hajf_key_t        key_i,
  input  logic [hajf_pkg::KW_W-1:0]  nwords_i,
  output logic                       done_o,
  output logic [hajf_pkg::IDX_W-1:0] slot_o
);
  import hajf_pkg::*;

  hajf_hphase_e phase_q, phase_d;
  logic [WIDX_W-1:0] idx_q, idx_d;
  logic [WORD_W-1:0] h_q, h_d;
  logic [WORD_W-1:0] a_q, a_d;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [WORD_W-1:0] prod_q, prod_d;
  logic              done_q, done_d;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] mix;
  logic              last;

  assign last = ({{(KW_W-WIDX_W){1'b0}}, idx_q} == (nwords_i - KW_W'(1)));

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      HP_IDLE: if (start_i) phase_d = HP_LOAD;
      HP_LOAD: phase_d = HP_M0;
      HP_M0:   phase_d = HP_M1;
      HP_M1:   phase_d = HP_M2;
      HP_M2:   phase_d = HP_MIX;
      HP_MIX:  phase_d = last ? HP_IDLE : HP_LOAD;
      default: phase_d = HP_IDLE;
    endcase
  end

  // shared multiplier operands: lo*lo, lo*hi, hi*lo of the low 64-bit product
  always_comb begin
    unique case (phase_q)
      HP_M0: begin
        mul_a = a_q[HALF_W-1:0];
        mul_b = HASH_MULT[HALF_W-1:0];
      end
      HP_M1: begin
        mul_a = a_q[HALF_W-1:0];
        mul_b = HASH_MULT[WORD_W-1:HALF_W];
      end
      HP_M2: begin
        mul_a = a_q[WORD_W-1:HALF_W];
        mul_b = HASH_MULT[HALF_W-1:0];
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mix = {acc_q[WORD_W-1:HALF_W] + prod_q[HALF_W-1:0], acc_q[HALF_W-1:0]};

  always_comb begin
    idx_d  = idx_q;
    h_d    = h_q;
    a_d    = a_q;
    acc_d  = acc_q;
    prod_d = WORD_W'(mul_a) * WORD_W'(mul_b);
    done_d = 1'b0;
    unique case (phase_q)
      HP_IDLE: begin
        if (start_i) begin
          idx_d = '0;
          h_d   = '0;
        end
      end
      HP_LOAD: a_d = h_q ^ key_i[idx_q];
      HP_M0:   ;
      HP_M1:   acc_d = prod_q;
      HP_M2:   acc_d[WORD_W-1:HALF_W] = acc_q[WORD_W-1:HALF_W] + prod_q[HALF_W-1:0];
      HP_MIX: begin
        h_d    = mix ^ (mix >> HASH_SHIFT);
        idx_d  = idx_q + WIDX_W'(1);
        done_d = last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= HP_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    h_q    <= h_d;
    a_q    <= a_d;
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign done_o = done_q;
  assign slot_o = h_q[HALF_W +: IDX_W];  // (h >> 32) mod capacity

endmodule

// File: hdl/hajf_store.sv
// Slot store: key words and valid marks, one write and one registered read
// per cycle. Depends on hajf_pkg.
module hajf_store (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [hajf_pkg::IDX_W-1:0] rd_addr_i,
  output hajf_pkg::hajf_key_t        rd_key_o,
  output logic                       rd_vld_o,
  input  hajf_pkg::hajf_wr_t         wr_i,
  input  hajf_pkg::hajf_key_t        wr_key_i
);
  import hajf_pkg::*;

  hajf_key_t key_mem [SET_CAPACITY];
  logic      vld_mem [SET_CAPACITY];
  hajf_key_t rd_key_q;
  logic      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.key_en) begin
      key_mem[wr_i.addr] <= wr_key_i;
    end
    if (wr_i.vld_en) begin
      vld_mem[wr_i.addr] <= wr_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_q <= key_mem[rd_addr_i];
      rd_vld_q <= vld_mem[rd_addr_i];
    end
  end

  assign rd_key_o = rd_key_q;
  assign rd_vld_o = rd_vld_q;

endmodule

// File: hdl/hash_anti_join_filter.sv
// Hash anti-join filter top level: sequencer, key capture and output register.
// Depends on hajf_pkg, hajf_hash and hajf_store.
//
// Input channel (in_valid_i/in_ready_o, in_data_i) takes one item at a time:
// clear, insert a build key, probe a key, or no-op. Output channel
// (out_valid_o/out_ready_i, out_data_o) gives the row tag of a probe whose key
// is absent, or an overflow report for an insert that met a full set.
// cfg_we_i/cfg_wdata_i set the key length in 64-bit words (reset 1).
// Per insert or probe item, with n active key words and p slots visited: the
// item transfers in, its n words pass through the shared hash multiplier, then
// each slot takes a registered read of the slot store and a compare. A result
// goes from the compare through the emit step to the output register. p is 1 on a
// lightly loaded set and up to 1024 on a full one.
// A clear item, and reset, sweep the 1024 valid marks at one slot per cycle;
// in_ready_o stays low for the whole sweep.
// A held result does not block the next input transfer; only a new result
// waits in the emit step until the output register is free.
module hash_anti_join_filter (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  hajf_pkg::hajf_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output hajf_pkg::hajf_out_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [hajf_pkg::KW_W-1:0] cfg_wdata_i
);
  import hajf_pkg::*;

  hajf_state_e      state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [KW_W-1:0]  kw_q, kw_d;
  logic [KW_W-1:0]  nw_q, nw_d;
  hajf_key_t        key_q, key_d;
  logic             ins_q, ins_d;
  logic [TAG_W-1:0] tag_q, tag_d;
  logic [IDX_W-1:0] slot_q, slot_d;
  logic [IDX_W-1:0] probe_q, probe_d;
  logic             out_valid_q, out_valid_d;
  hajf_out_t        out_q, out_d;

  logic [KW_W-1:0]   nw_act;
  logic [WORD_W-1:0] in_words [IN_KEY_WORDS];
  hajf_key_t         in_key;
  logic              is_search;
  logic              hash_start;
  logic              hash_done;
  logic [IDX_W-1:0]  hash_slot;
  logic              rd_en;
  hajf_key_t         rd_key;
  logic              rd_vld;
  hajf_wr_t          wr;
  logic              match;
  logic              walk_last;

  hajf_hash u_hash (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (hash_start),
    .key_i    (key_q),
    .nwords_i (nw_q),
    .done_o   (hash_done),
    .slot_o   (hash_slot)
  );

  hajf_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (slot_q),
    .rd_key_o  (rd_key),
    .rd_vld_o  (rd_vld),
    .wr_i      (wr),
    .wr_key_i  (key_q)
  );

  // key length clamped to 1..MAX_KEY_WORDS
  always_comb begin
    if (kw_q == '0) begin
      nw_act = KW_W'(1);
    end else if (kw_q > KW_W'(MAX_KEY_WORDS)) begin
      nw_act = KW_W'(MAX_KEY_WORDS);
    end else begin
      nw_act = kw_q;
    end
  end

  assign in_words[0] = in_data_i.key_word_0;
  assign in_words[1] = in_data_i.key_word_1;
  assign in_words[2] = in_data_i.key_word_2;
  assign in_words[3] = in_data_i.key_word_3;

  // unused words are zero so stored slots are fully written
  always_comb begin
    for (int i = 0; i < MAX_KEY_WORDS; i++) begin
      if (i < IN_KEY_WORDS && KW_W'(i) < nw_act) begin
        in_key[i] = in_words[i];
      end else begin
        in_key[i] = '0;
      end
    end
  end

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < MAX_KEY_WORDS; i++) begin
      if (KW_W'(i) < nw_q && rd_key[i] != key_q[i]) begin
        match = 1'b0;
      end
    end
  end

  assign is_search = (in_data_i.action == ACT_INSERT) || (in_data_i.action == ACT_PROBE);
  assign walk_last = (probe_q == IDX_W'(SET_CAPACITY - 1));
  assign in_ready_o = (state_q == ST_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == IDX_W'(SET_CAPACITY - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.action == ACT_CLEAR) begin
            state_d = ST_CLEAR;
          end else if (is_search) begin
            state_d = ST_HASH;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) state_d = ST_READ;
      end
      ST_READ: state_d = ST_CHECK;
      ST_CHECK: begin
        priority if (!rd_vld) begin
          state_d = ins_q ? ST_IDLE : ST_EMIT;
        end else if (match) begin
          state_d = ST_IDLE;
        end else if (walk_last) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    clr_cnt_d   = clr_cnt_q;
    count_d     = count_q;
    kw_d        = cfg_we_i ? cfg_wdata_i : kw_q;
    nw_d        = nw_q;
    key_d       = key_q;
    ins_d       = ins_q;
    tag_d       = tag_q;
    slot_d      = slot_q;
    probe_d     = probe_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    wr          = '0;
    rd_en       = 1'b0;
    hash_start  = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        wr.vld_en = 1'b1;
        wr.addr   = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          key_d = in_key;
          nw_d  = nw_act;
          ins_d = (in_data_i.action == ACT_INSERT);
          tag_d = in_data_i.row_tag;
          if (in_data_i.action == ACT_CLEAR) begin
            count_d   = '0;
            clr_cnt_d = '0;
          end else if (is_search) begin
            hash_start = 1'b1;
          end
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          slot_d  = hash_slot;
          probe_d = '0;
        end
      end
      ST_READ: rd_en = 1'b1;
      ST_CHECK: begin
        if (!rd_vld) begin
          if (ins_q) begin
            wr.key_en = 1'b1;
            wr.vld_en = 1'b1;
            wr.vld    = 1'b1;
            wr.addr   = slot_q;
            count_d   = count_q + CNT_W'(1);
          end
        end else if (!match) begin
          slot_d  = (slot_q == IDX_W'(SET_CAPACITY - 1)) ? '0 : slot_q + IDX_W'(1);
          probe_d = probe_q + IDX_W'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.out_tag    = ins_q ? '0 : tag_q;
          out_d.overflow   = ins_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      count_q     <= '0;
      kw_q        <= KW_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      count_q     <= count_d;
      kw_q        <= kw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    nw_q    <= nw_d;
    key_q   <= key_d;
    ins_q   <= ins_d;
    tag_q   <= tag_d;
    slot_q  <= slot_d;
    probe_q <= probe_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(SET_CAPACITY))
    else $error("entry count above capacity");

  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> (count_q == '0) && !in_ready_o)
    else $error("clear sweep with nonzero count or open input");

  a_hash_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == ST_HASH))
    else $error("hash result outside hash step");

  a_full_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK) && rd_vld && !match && walk_last && ins_q
      |-> (count_q == CNT_W'(SET_CAPACITY)))
    else $error("insert walk exhausted on a set that is not full");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && is_search |=> (state_q == ST_HASH))
    else $error("search transfer did not start hashing");

endmodule

// File: dv/hash_anti_join_filter_tb.sv
`timescale 1ns / 1ps
// Testbench for hash_anti_join_filter: directed and random build/probe/clear traffic,
// a scoreboard class that predicts unmatched probe tags and overflow reports.
// Depends on hajf_pkg and the hash_anti_join_filter RTL.
module hash_anti_join_filter_tb;
  import hajf_pkg::*;

  localparam int unsigned IDLE_SETTLE = 2600;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned POOL_DEPTH  = 64;
  localparam int unsigned PHASE_ITEMS = 4;

  class anti_join_scoreboard;
    hajf_key_t        key_slots[SET_CAPACITY];
    bit               slot_used[SET_CAPACITY];
    logic [KW_W-1:0]  key_words;
    hajf_out_t        expected_rows[$];
    int unsigned      errors;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      key_words = KW_RESET;
      errors = 0;
    endfunction

    function void set_key_words(logic [KW_W-1:0] v);
      key_words = v;
    endfunction

    function int unsigned key_len();
      if (key_words == 0) return 1;
      if (key_words > MAX_KEY_WORDS) return MAX_KEY_WORDS;
      return key_words;
    endfunction

    function int unsigned pending();
      return expected_rows.size();
    endfunction

    function void add_expected(hajf_out_t row);
      expected_rows.insert(expected_rows.size(), row);
    endfunction

    function int unsigned home_slot(hajf_key_t k, int unsigned n);
      logic [WORD_W-1:0] h;
      h = '0;
      for (int unsigned i = 0; i < n; i++) begin
        h = (h ^ k[i]) * HASH_MULT;
        h = h ^ (h >> HASH_SHIFT);
      end
      return h[HALF_W +: IDX_W];
    endfunction

    // linear walk; free_slot is SET_CAPACITY when no empty slot exists
    function bit lookup(hajf_key_t k, int unsigned n, output int unsigned free_slot);
      int unsigned s;
      bit same;
      s = home_slot(k, n);
      free_slot = SET_CAPACITY;
      for (int unsigned p = 0; p < SET_CAPACITY; p++) begin
        if (!slot_used[s]) begin
          free_slot = s;
          return 1'b0;
        end
        same = 1'b1;
        for (int unsigned i = 0; i < n; i++) begin
          if (key_slots[s][i] != k[i]) same = 1'b0;
        end
        if (same) return 1'b1;
        s = (s + 1) % SET_CAPACITY;
      end
      return 1'b0;
    endfunction

    function void record_transfer(hajf_in_t it);
      hajf_key_t   raw;
      hajf_key_t   k;
      hajf_out_t   row;
      int unsigned n;
      int unsigned free_slot;
      bit          hit;
      case (it.action)
        ACT_CLEAR: foreach (slot_used[i]) slot_used[i] = 1'b0;
        ACT_NOP: ;
        default: begin
          n = key_len();
          raw = {it.key_word_3, it.key_word_2, it.key_word_1, it.key_word_0};
          for (int unsigned i = 0; i < MAX_KEY_WORDS; i++) k[i] = (i < n) ? raw[i] : '0;
          hit = lookup(k, n, free_slot);
          if (!hit) begin
            if (it.action == ACT_INSERT) begin
              if (free_slot == SET_CAPACITY) begin
                row.out_tag = '0;
                row.overflow = 1'b1;
                add_expected(row);
              end else begin
                key_slots[free_slot] = k;
                slot_used[free_slot] = 1'b1;
              end
            end else begin
              row.out_tag = it.row_tag;
              row.overflow = 1'b0;
              add_expected(row);
            end
          end
        end
      endcase
    endfunction

    function void check_result(hajf_out_t got);
      hajf_out_t exp_row;
      if (expected_rows.size() == 0) begin
        $error("unexpected result: out_tag %h overflow %b", got.out_tag, got.overflow);
        errors++;
        return;
      end
      exp_row = expected_rows.pop_front();
      if (got.out_tag !== exp_row.out_tag) begin
        $error("out_tag: expected %h, actual %h", exp_row.out_tag, got.out_tag);
        errors++;
      end
      if (got.overflow !== exp_row.overflow) begin
        $error("overflow: expected %b, actual %b", exp_row.overflow, got.overflow);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  hajf_in_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  hajf_out_t        out_data_o;
  logic             cfg_we_i    = 1'b0;
  logic [KW_W-1:0]  cfg_wdata_i = '0;

  anti_join_scoreboard sb;
  hajf_key_t           key_pool[$];
  bit                  no_idle     = 1'b0;
  bit                  rx_hold     = 1'b0;
  int unsigned         force_probe = 0;

  hash_anti_join_filter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WORD_W'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic hajf_key_t fresh_key();
    hajf_key_t k;
    for (int unsigned i = 0; i < MAX_KEY_WORDS; i++) k[i] = rand_word();
    return k;
  endfunction

  function automatic void remember_key(hajf_key_t k);
    key_pool.insert(key_pool.size(), k);
    if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
  endfunction

  // pool keys give hits; bit flips give near misses; noise in unused words must not matter
  function automatic hajf_key_t pick_key();
    hajf_key_t   k;
    int unsigned r;
    int unsigned w;
    int unsigned b;
    r = $urandom_range(0, 9);
    if (key_pool.size() == 0 || r < 3) return fresh_key();
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r == 3) begin
      w = $urandom_range(0, MAX_KEY_WORDS - 1);
      b = $urandom_range(0, WORD_W - 1);
      k[w][b] = ~k[w][b];
    end else if (r == 4) begin
      for (int unsigned i = sb.key_len(); i < MAX_KEY_WORDS; i++) k[i] = rand_word();
    end
    return k;
  endfunction

  function automatic hajf_in_t make_item(logic [ACT_W-1:0] act, hajf_key_t k,
                                         logic [TAG_W-1:0] tag);
    hajf_in_t it;
    it.action     = act;
    it.key_word_0 = k[0];
    it.key_word_1 = k[1];
    it.key_word_2 = k[2];
    it.key_word_3 = k[3];
    it.row_tag    = tag;
    return it;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(out_data_o);
  end

  initial begin
    int unsigned stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        rx_hold = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if (!no_idle) stall = pick_gap();
      end
    end
  end

  task automatic send_item(input hajf_in_t it);
    int unsigned gap;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.record_transfer(it);
    gap = no_idle ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // items without a result may still be in flight: settle before the write
  task automatic write_key_words(input logic [KW_W-1:0] v);
    wait_drained();
    repeat (IDLE_SETTLE) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_key_words(v);
  endtask

  task automatic random_item();
    hajf_key_t   k;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (force_probe != 0) begin
      force_probe--;
      send_item(make_item(ACT_PROBE, fresh_key(), $urandom));
    end else if (r < 2) begin
      send_item(make_item(ACT_CLEAR, fresh_key(), $urandom));
    end else if (r < 5) begin
      send_item(make_item(ACT_NOP, pick_key(), $urandom));
    end else if (r < 50) begin
      k = pick_key();
      send_item(make_item(ACT_INSERT, k, $urandom));
      remember_key(k);
    end else begin
      send_item(make_item(ACT_PROBE, pick_key(), $urandom));
    end
  endtask

  task automatic run_phase(input logic [KW_W-1:0] kw, input int unsigned items,
                           input int unsigned phase_no);
    write_key_words(kw);
    no_idle = (phase_no == 5);
    if (phase_no % 2 == 0) send_item(make_item(ACT_CLEAR, fresh_key(), $urandom));
    for (int unsigned i = 0; i < items; i++) begin
      if (phase_no == 1 && i == 0) begin
        rx_hold = 1'b1;
        force_probe = items;
      end
      if (phase_no == 3 && i == 2) wait_drained();
      random_item();
    end
    no_idle = 1'b0;
  endtask

  // fill to capacity, then overflow inserts and full-length walks
  task automatic run_fill();
    hajf_key_t k;
    write_key_words(KW_W'(1));
    send_item(make_item(ACT_CLEAR, fresh_key(), $urandom));
    key_pool.delete();
    for (int unsigned i = 0; i < SET_CAPACITY; i++) begin
      k = fresh_key();
      k[0] = {$urandom, i};
      send_item(make_item(ACT_INSERT, k, $urandom));
      if (i % 16 == 0) remember_key(k);
    end
    for (int unsigned j = 0; j < 24; j++) begin
      k = fresh_key();
      k[0] = {$urandom, 32'hFFFF_0000 + j};
      case ($urandom_range(0, 3))
        0: send_item(make_item(ACT_INSERT, k, $urandom));
        1: send_item(make_item(ACT_PROBE, k, $urandom));
        2: send_item(make_item(ACT_PROBE, key_pool[$urandom_range(0, key_pool.size() - 1)],
                               $urandom));
        default: send_item(make_item(ACT_INSERT,
                                     key_pool[$urandom_range(0, key_pool.size() - 1)],
                                     $urandom));
      endcase
    end
    send_item(make_item(ACT_CLEAR, fresh_key(), $urandom));
    send_item(make_item(ACT_PROBE, key_pool[0], $urandom));
    send_item(make_item(ACT_INSERT, key_pool[0], $urandom));
    send_item(make_item(ACT_PROBE, key_pool[0], $urandom));
  endtask

  initial begin
    hajf_key_t       k4;
    hajf_key_t       k;
    logic [KW_W-1:0] kw_seq[8];
    sb = new();
    kw_seq = '{KW_W'(4), KW_W'(2), KW_W'(5), KW_W'(1), KW_W'(3), KW_W'(6), KW_W'(0),
               KW_W'(7)};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // one-word keys, reset length
    send_item(make_item(ACT_PROBE, '0, '0));
    send_item(make_item(ACT_INSERT, '0, 32'h1234_5678));
    send_item(make_item(ACT_INSERT, '0, '1));
    send_item(make_item(ACT_PROBE, '0, '1));
    send_item(make_item(ACT_PROBE, '1, '1));
    send_item(make_item(ACT_INSERT, '1, '0));
    k = fresh_key();
    k[0] = '1;
    send_item(make_item(ACT_PROBE, k, 32'h0000_0001));
    send_item(make_item(ACT_NOP, '1, '1));
    send_item(make_item(ACT_CLEAR, '1, '1));
    send_item(make_item(ACT_PROBE, '0, 32'hA5A5_A5A5));
    k4 = {{WORD_W'(0)}, {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
    send_item(make_item(ACT_INSERT, k4, $urandom));

    // length above range, keys still held
    write_key_words(KW_W'(7));
    send_item(make_item(ACT_PROBE, k4, $urandom));
    k4[3] = {$urandom, $urandom};
    send_item(make_item(ACT_INSERT, k4, $urandom));
    send_item(make_item(ACT_PROBE, k4, $urandom));
    k = k4;
    k[3][0] = ~k[3][0];
    send_item(make_item(ACT_PROBE, k, $urandom));
    send_item(make_item(ACT_INSERT, '1, $urandom));
    send_item(make_item(ACT_PROBE, '1, $urandom));

    // zero length counts as one word
    write_key_words(KW_W'(0));
    send_item(make_item(ACT_PROBE, k4, $urandom));
    send_item(make_item(ACT_CLEAR, '0, '0));

    for (int unsigned p = 0; p < 8; p++) run_phase(kw_seq[p], PHASE_ITEMS, p);
    run_fill();

    wait_drained();
    repeat (IDLE_SETTLE) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
